// ===== src/rvse_pkg.sv =====
// Shared types, constants and helper functions for the RPN value stack engine.
package rvse_pkg;

    // Stack geometry and field widths
    localparam int STACK_CAPACITY = 16;
    localparam int PTR_W          = $clog2(STACK_CAPACITY);
    localparam int LVL_W          = $clog2(STACK_CAPACITY + 1);
    localparam int VAL_W          = 32;
    localparam int ACT_W          = 3;
    localparam int STS_W          = 2;

    // Stream packing
    localparam int IN_DATA_W    = 32;
    localparam int IN_USER_W    = ACT_W;
    localparam int OUT_FIELDS_W = VAL_W + LVL_W + LVL_W + STS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // Action codes carried on the input tuser
    localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_AVG  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ROT  = 3'd5;

    typedef enum logic [STS_W-1:0] {
        STS_DONE = 2'd0,
        STS_FEW  = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    // Stack positions relative to the current fill level
    typedef enum logic [1:0] {
        SLOT_NEW,
        SLOT_TOP,
        SLOT_SEC,
        SLOT_THR
    } slot_t;

    // Write data sources
    typedef enum logic [2:0] {
        DSEL_VAL,
        DSEL_TOP,
        DSEL_SEC,
        DSEL_THR,
        DSEL_AVG
    } dsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_TOP,
        ST_RD_SEC,
        ST_RD_THR,
        ST_WAIT,
        ST_WR_A,
        ST_WR_B,
        ST_WR_C,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    accept;
        logic    rd_en;
        slot_t   rd_slot;
        logic    wr_en;
        slot_t   wr_slot;
        dsel_t   wr_dsel;
        logic    sts_we;
        status_t sts_code;
        logic    finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LVL_W-1:0] fill;
        logic             out_free;
    } dp_stat_t;

    // Outcome of an action given the current fill level.
    function automatic status_t check_action(input logic [ACT_W-1:0] act,
                                             input logic [LVL_W-1:0] fill);
        status_t code;
        code = STS_DONE;
        unique case (act) inside
            ACT_PUSH, ACT_INS: if (fill >= LVL_W'(STACK_CAPACITY)) code = STS_FULL;
            ACT_POP:           if (fill == '0) code = STS_FEW;
            ACT_DEL, ACT_AVG:  if (fill < LVL_W'(2)) code = STS_FEW;
            ACT_ROT:           if (fill < LVL_W'(3)) code = STS_FEW;
            default:           code = STS_DONE;
        endcase
        return code;
    endfunction

    // True for a Q16.16 value strictly above zero.
    function automatic logic is_pos(input logic [VAL_W-1:0] v);
        return !v[VAL_W-1] && (v != '0);
    endfunction

endpackage

// ===== src/rvse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rvse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rvse_datapath.sv =====
// Datapath of the stack engine: entry memory, top-entry holding registers,
// fill and positive counters, and the result register.
module rvse_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rvse_pkg::ctrl_cmd_t             cmd,
    output rvse_pkg::dp_stat_t              stat,
    input  logic [rvse_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [rvse_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rvse_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rvse_pkg::*;

    logic [ACT_W-1:0] act_reg;
    logic [VAL_W-1:0] val_reg;
    logic [LVL_W-1:0] fill_reg, fill_next;
    logic [LVL_W-1:0] pos_reg, pos_next;
    status_t          sts_reg;
    logic [VAL_W-1:0] top_reg, sec_reg, thr_reg;
    logic             rd_pend_reg;
    slot_t            rd_slot_pend_reg;
    logic             m_tvalid_reg;
    logic [VAL_W-1:0] out_popped_reg;
    logic [LVL_W-1:0] out_depth_reg, out_pos_reg;
    status_t          out_sts_reg;

    logic [VAL_W-1:0] popped_next;
    logic [VAL_W:0]   avg_sum;
    logic [VAL_W-1:0] avg_val;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [VAL_W-1:0] wr_data, rd_data;
    logic             out_free;
    logic             commit;

    // Address of a stack position relative to the current fill level.
    function automatic logic [PTR_W-1:0] slot_addr(input slot_t slot,
                                                   input logic [LVL_W-1:0] fill);
        logic [PTR_W-1:0] base;
        base = fill[PTR_W-1:0];
        case (slot)
            SLOT_NEW: return base;
            SLOT_TOP: return base - PTR_W'(1);
            SLOT_SEC: return base - PTR_W'(2);
            default:  return base - PTR_W'(3);
        endcase
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = cmd.finish && out_free;

    assign stat.action   = act_reg;
    assign stat.fill     = fill_reg;
    assign stat.out_free = out_free;

    // Average of the top two entries at full precision, rounded down.
    assign avg_sum = {top_reg[VAL_W-1], top_reg} + {sec_reg[VAL_W-1], sec_reg};
    assign avg_val = avg_sum[VAL_W:1];

    // Memory write data selection.
    always_comb begin
        case (cmd.wr_dsel)
            DSEL_VAL: wr_data = val_reg;
            DSEL_TOP: wr_data = top_reg;
            DSEL_SEC: wr_data = sec_reg;
            DSEL_THR: wr_data = thr_reg;
            default:  wr_data = avg_val;
        endcase
    end

    assign wr_addr = slot_addr(cmd.wr_slot, fill_reg);
    assign rd_addr = slot_addr(cmd.rd_slot, fill_reg);

    rvse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_CAPACITY)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Counter updates for a completed action.
    always_comb begin
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        popped_next = '0;
        if (sts_reg == STS_DONE) begin
            case (act_reg) inside
                ACT_PUSH, ACT_INS: begin
                    fill_next = fill_reg + LVL_W'(1);
                    pos_next  = pos_reg + LVL_W'(is_pos(val_reg));
                end
                ACT_POP: begin
                    fill_next   = fill_reg - LVL_W'(1);
                    pos_next    = pos_reg - LVL_W'(is_pos(top_reg));
                    popped_next = top_reg;
                end
                ACT_DEL: begin
                    fill_next = fill_reg - LVL_W'(1);
                    pos_next  = pos_reg - LVL_W'(is_pos(sec_reg));
                end
                ACT_AVG: begin
                    fill_next = fill_reg - LVL_W'(1);
                    pos_next  = pos_reg - LVL_W'(is_pos(top_reg))
                                - LVL_W'(is_pos(sec_reg)) + LVL_W'(is_pos(avg_val));
                end
                default: begin
                    fill_next = fill_reg;
                    pos_next  = pos_reg;
                end
            endcase
        end
    end

    // Control registers: counters, read tracking and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            pos_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
            if (commit) begin
                fill_reg     <= fill_next;
                pos_reg      <= pos_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request latch, read captures and result fields.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg <= s_tuser;
            val_reg <= s_tdata;
        end
        if (cmd.sts_we) begin
            sts_reg <= cmd.sts_code;
        end
        rd_slot_pend_reg <= cmd.rd_slot;
        if (rd_pend_reg) begin
            case (rd_slot_pend_reg)
                SLOT_TOP: top_reg <= rd_data;
                SLOT_SEC: sec_reg <= rd_data;
                default:  thr_reg <= rd_data;
            endcase
        end
        if (commit) begin
            out_popped_reg <= popped_next;
            out_depth_reg  <= fill_next;
            out_pos_reg    <= pos_next;
            out_sts_reg    <= sts_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_sts_reg, out_pos_reg, out_depth_reg,
                       out_popped_reg};

endmodule

// ===== src/rvse_ctrl.sv =====
// Controller state machine that sequences memory reads and writes per action.
module rvse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rvse_pkg::dp_stat_t  stat,
    output rvse_pkg::ctrl_cmd_t cmd
);
    import rvse_pkg::*;

    state_t  state_reg, state_next;
    status_t code;

    assign code = check_action(stat.action, stat.fill);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (code != STS_DONE) begin
                    state_next = ST_FINISH;
                end else begin
                    unique case (stat.action) inside
                        ACT_PUSH: state_next = ST_WR_A;
                        ACT_INS:  state_next = (stat.fill == '0) ? ST_WR_A : ST_RD_TOP;
                        ACT_POP, ACT_DEL, ACT_AVG, ACT_ROT: state_next = ST_RD_TOP;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RD_TOP: begin
                state_next = (stat.action == ACT_POP || stat.action == ACT_INS)
                             ? ST_WAIT : ST_RD_SEC;
            end
            ST_RD_SEC: begin
                state_next = (stat.action == ACT_ROT) ? ST_RD_THR : ST_WAIT;
            end
            ST_RD_THR: state_next = ST_WAIT;
            ST_WAIT: begin
                state_next = (stat.action == ACT_POP) ? ST_FINISH : ST_WR_A;
            end
            ST_WR_A: begin
                // Insert on an empty stack needs only the one write.
                state_next = (stat.action == ACT_ROT ||
                              (stat.action == ACT_INS && stat.fill != '0))
                             ? ST_WR_B : ST_FINISH;
            end
            ST_WR_B: begin
                state_next = (stat.action == ACT_ROT) ? ST_WR_C : ST_FINISH;
            end
            ST_WR_C: state_next = ST_FINISH;
            ST_FINISH: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd          = '0;
        cmd.rd_slot  = SLOT_TOP;
        cmd.wr_slot  = SLOT_NEW;
        cmd.wr_dsel  = DSEL_VAL;
        cmd.sts_code = STS_DONE;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_DECODE: begin
                cmd.sts_we   = 1'b1;
                cmd.sts_code = code;
            end
            ST_RD_TOP: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = SLOT_TOP;
            end
            ST_RD_SEC: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = SLOT_SEC;
            end
            ST_RD_THR: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = SLOT_THR;
            end
            ST_WAIT: begin
                cmd.rd_en = 1'b0;
            end
            ST_WR_A: begin
                cmd.wr_en = 1'b1;
                unique case (stat.action) inside
                    ACT_INS: begin
                        cmd.wr_slot = SLOT_NEW;
                        cmd.wr_dsel = (stat.fill == '0) ? DSEL_VAL : DSEL_TOP;
                    end
                    ACT_DEL: begin
                        cmd.wr_slot = SLOT_SEC;
                        cmd.wr_dsel = DSEL_TOP;
                    end
                    ACT_AVG: begin
                        cmd.wr_slot = SLOT_SEC;
                        cmd.wr_dsel = DSEL_AVG;
                    end
                    ACT_ROT: begin
                        cmd.wr_slot = SLOT_TOP;
                        cmd.wr_dsel = DSEL_THR;
                    end
                    default: begin
                        cmd.wr_slot = SLOT_NEW;
                        cmd.wr_dsel = DSEL_VAL;
                    end
                endcase
            end
            ST_WR_B: begin
                cmd.wr_en = 1'b1;
                if (stat.action == ACT_ROT) begin
                    cmd.wr_slot = SLOT_SEC;
                    cmd.wr_dsel = DSEL_TOP;
                end else begin
                    cmd.wr_slot = SLOT_TOP;
                    cmd.wr_dsel = DSEL_VAL;
                end
            end
            ST_WR_C: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_slot = SLOT_THR;
                cmd.wr_dsel = DSEL_SEC;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
            end
            default: begin
                cmd.finish = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/rpn_value_stack_engine_unit.sv =====
// Top level of the RPN value stack engine: controller, datapath and checks.
//
//   Channel  Direction  Ports                        Contents
//   s_       in         tvalid tready tdata tuser    operand value; action code
//   m_       out        tvalid tready tdata          popped, depth, positives, status
//
// A request runs idle, decode, its memory steps, finish. Refused or unused actions
// have none; push and insert on an empty stack write; pop reads; insert reads, then
// writes two; delete and average read two, write one; rotate three of each. The
// controller issues one memory access per cycle and awaits registered read data.
// Reset (aresetn low, synchronous) empties the stack at once; memory contents
// are left as they are. A stalled result holds the engine in its last step.
module rpn_value_stack_engine_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rvse_pkg::IN_DATA_W-1:0]  s_tdata,  // [31:0] operand_value
    input  logic [rvse_pkg::IN_USER_W-1:0]  s_tuser,  // [2:0] action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rvse_pkg::OUT_DATA_W-1:0] m_tdata   // [31:0] popped_value,
                                                      // [36:32] depth_now,
                                                      // [41:37] positive_count,
                                                      // [43:42] status
);
    import rvse_pkg::*;

    ctrl_cmd_t        cmd;
    dp_stat_t         stat;
    logic [LVL_W-1:0] res_depth, res_pos;
    logic [STS_W-1:0] res_sts;

    rvse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rvse_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Result fields for the checks below.
    assign res_depth = m_tdata[VAL_W +: LVL_W];
    assign res_pos   = m_tdata[VAL_W + LVL_W +: LVL_W];
    assign res_sts   = m_tdata[VAL_W + 2 * LVL_W +: STS_W];

    // The engine works on one request at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // Depth never exceeds capacity and positives never exceed depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_depth <= LVL_W'(STACK_CAPACITY) && res_pos <= res_depth))
        else $error("depth or positive count out of range");

    // A full refusal only happens on a full stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_sts == STS_FULL) |-> res_depth == LVL_W'(STACK_CAPACITY))
        else $error("full status reported on a stack that is not full");

    // A too-few refusal only happens with fewer than three entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_sts == STS_FEW) |-> res_depth < LVL_W'(3))
        else $error("too-few status reported with three or more entries");

    // Command groups never read and write the memory in the same step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("memory read and write issued together");

endmodule
